// ----- design/dat_pkg.sv -----
// Shared types and constants for the double-array trie engine.
// Used by the interfaces, the memory, the address unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dat_pkg;

    localparam int CAPACITY_DEF = 4096;
    localparam int ALPHABET_DEF = 27;
    localparam int SYM_W        = 5;
    localparam int NODE_OUT_W   = 12;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [SYM_W-1:0]      t_symbol;
    typedef logic [NODE_OUT_W-1:0] t_end_node;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_T,
        S_TCHK,
        S_G,
        S_GW,
        S_DEC,
        S_SI,
        S_SW,
        S_M0,
        S_M1,
        S_MG,
        S_MGW,
        S_MCLR,
        S_SETB,
        S_CLAIM,
        S_END,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- design/dat_if.sv -----
// Handshake interfaces for the request and response channels.
// Depends on dat_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface dat_req_if;
    logic             valid;
    logic             ready;
    logic             opcode;
    dat_pkg::t_symbol symbol;
    logic             word_end;

    modport source(output valid, output opcode, output symbol, output word_end, input ready);
    modport sink(input valid, input opcode, input symbol, input word_end, output ready);
endinterface

interface dat_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic               status;
    dat_pkg::t_end_node end_node;

    modport source(output valid, output found, output status, output end_node, input ready);
    modport sink(input valid, input found, input status, input end_node, output ready);
endinterface

`default_nettype wire

// ----- design/double_array_trie_engine.sv -----
// Top level of the double-array trie dictionary engine.
// Depends on dat_pkg, dat_if, dat_ram and dat_calc.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps a dictionary of words in a double-array trie. Words arrive
// on the request channel one symbol per beat: opcode selects lookup or insert,
// symbol carries the code 1..ALPHABET, and word_end marks the last beat of a
// word. Only the last beat of a word yields a response beat, carrying found,
// status (store full) and the node the word reached.
// The block takes one beat at a time: ready is high only while the sequencer
// waits for work. A lookup symbol is limited by the reads of the base and
// check memories. An insert that must place a new child first scans the
// node's children, one alphabet symbol at a time, then may search for a new
// base, testing one slot at a time through the shared slot unit, and
// relocates each child in turn. Ending a word passes through the END state,
// and through FIN too when the word is still alive. Everything runs through
// one shared adder and comparator and the single read port of each memory.
// After reset the engine sweeps both memories, one entry per cycle, and
// ready stays low until that clearing pass is done.
// The response sits in an output register; if the receiver stalls, the
// engine still takes beats that end no word, and holds a word-ending beat
// until the previous response has been taken.

module double_array_trie_engine #(
    parameter int CAPACITY = dat_pkg::CAPACITY_DEF,
    parameter int ALPHABET = dat_pkg::ALPHABET_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    dat_req_if.sink   i_req,
    dat_rsp_if.source o_rsp
);

    localparam int NW = $clog2(CAPACITY);
    localparam int DW = $clog2(ALPHABET + 1);
    localparam int IW = $clog2(ALPHABET);

    localparam logic [NW-1:0] LAST_SLOT = NW'(CAPACITY - 1);
    localparam logic [DW-1:0] LAST_SYM  = DW'(ALPHABET);

    dat_pkg::t_state r_state, n_state;

    logic          r_op, r_end, r_dead, r_term, r_tfree, r_ok;
    logic [DW-1:0] r_sym, r_d, r_cnt, r_k, r_mk;
    logic [NW-1:0] r_cur, r_sb, r_t, r_b, r_addr, r_told, r_clr;
    logic [NW:0]   r_gent;
    logic [DW-1:0] r_clist [ALPHABET];

    logic          r_ovalid, r_found, r_status;
    logic [NW-1:0] r_node;

    // Memory ports.
    logic          b_we, c_we;
    logic [NW-1:0] b_waddr, c_waddr, b_raddr, c_raddr;
    logic [NW:0]   b_wdata, c_wdata, b_rdata, c_rdata;

    // Shared slot unit.
    logic [NW-1:0] calc_base, calc_key;
    logic [DW-1:0] calc_off;
    logic [NW:0]   calc_sum;
    logic          calc_inr, calc_match, calc_unset;

    logic accept, out_free, sym_bad, rsp_load;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign sym_bad  = (int'(i_req.symbol) > ALPHABET);

    // The response register is loaded when a word ends, dead or alive.
    assign rsp_load = (r_state == dat_pkg::S_FIN) ||
                      (r_state == dat_pkg::S_END && r_end && out_free && r_dead);

    assign i_req.ready    = (r_state == dat_pkg::S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.found    = r_found;
    assign o_rsp.status   = r_status;
    assign o_rsp.end_node = dat_pkg::NODE_OUT_W'(r_node);

    dat_ram #(.DEPTH(CAPACITY), .WIDTH(NW + 1)) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    dat_ram #(.DEPTH(CAPACITY), .WIDTH(NW + 1)) u_check_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    dat_calc #(.CAPACITY(CAPACITY), .ALPHABET(ALPHABET)) u_calc (
        .i_base     (calc_base),
        .i_offset   (calc_off),
        .i_entry    (c_rdata),
        .i_key      (calc_key),
        .o_sum      (calc_sum),
        .o_in_range (calc_inr),
        .o_match    (calc_match),
        .o_unset    (calc_unset)
    );

    // Operand selection for the shared slot unit.
    always_comb begin
        calc_base = r_sb;
        calc_off  = r_sym;
        calc_key  = r_cur;
        case (r_state)
            dat_pkg::S_T: begin
                calc_base = b_rdata[NW:1];
            end
            dat_pkg::S_G: begin
                calc_off = r_d;
            end
            dat_pkg::S_SI: begin
                calc_base = r_b;
                calc_off  = (r_k == '0) ? r_sym : r_clist[IW'(r_k - 1'b1)];
            end
            dat_pkg::S_M0, dat_pkg::S_MCLR: begin
                calc_off = r_clist[IW'(r_mk)];
            end
            dat_pkg::S_M1: begin
                calc_base = r_b;
                calc_off  = r_clist[IW'(r_mk)];
            end
            dat_pkg::S_MG: begin
                calc_base = r_gent[NW:1];
                calc_off  = r_d;
            end
            dat_pkg::S_MGW: begin
                calc_key = r_told;
            end
            dat_pkg::S_CLAIM: begin
                calc_base = r_b;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dat_pkg::S_CLEAR: begin
                if (r_clr == LAST_SLOT) n_state = dat_pkg::S_IDLE;
            end
            dat_pkg::S_IDLE: begin
                if (accept) begin
                    if (r_dead || i_req.symbol == '0 || sym_bad) n_state = dat_pkg::S_END;
                    else n_state = dat_pkg::S_BASE;
                end
            end
            dat_pkg::S_BASE: n_state = dat_pkg::S_T;
            dat_pkg::S_T:    n_state = dat_pkg::S_TCHK;
            dat_pkg::S_TCHK: begin
                if ((r_ok && calc_match) || r_op == dat_pkg::OP_LOOKUP) begin
                    n_state = dat_pkg::S_END;
                end else begin
                    n_state = dat_pkg::S_G;
                end
            end
            dat_pkg::S_G:  n_state = dat_pkg::S_GW;
            dat_pkg::S_GW: n_state = (r_d == LAST_SYM) ? dat_pkg::S_DEC : dat_pkg::S_G;
            dat_pkg::S_DEC: begin
                n_state = (r_cnt != '0 && r_tfree) ? dat_pkg::S_END : dat_pkg::S_SI;
            end
            dat_pkg::S_SI: begin
                if (!calc_inr) begin
                    if (r_k == '0 || r_b == LAST_SLOT) n_state = dat_pkg::S_END;
                end else begin
                    n_state = dat_pkg::S_SW;
                end
            end
            dat_pkg::S_SW: begin
                if (calc_unset) begin
                    if (r_k == r_cnt) begin
                        n_state = (r_cnt == '0) ? dat_pkg::S_SETB : dat_pkg::S_M0;
                    end else begin
                        n_state = dat_pkg::S_SI;
                    end
                end else begin
                    n_state = (r_b == LAST_SLOT) ? dat_pkg::S_END : dat_pkg::S_SI;
                end
            end
            dat_pkg::S_M0:  n_state = dat_pkg::S_M1;
            dat_pkg::S_M1:  n_state = dat_pkg::S_MG;
            dat_pkg::S_MG:  n_state = dat_pkg::S_MGW;
            dat_pkg::S_MGW: n_state = (r_d == LAST_SYM) ? dat_pkg::S_MCLR : dat_pkg::S_MG;
            dat_pkg::S_MCLR: begin
                n_state = (r_mk + 1'b1 == r_cnt) ? dat_pkg::S_SETB : dat_pkg::S_M0;
            end
            dat_pkg::S_SETB:  n_state = dat_pkg::S_CLAIM;
            dat_pkg::S_CLAIM: n_state = dat_pkg::S_END;
            dat_pkg::S_END: begin
                if (!r_end) n_state = dat_pkg::S_IDLE;
                else if (out_free) n_state = r_dead ? dat_pkg::S_IDLE : dat_pkg::S_FIN;
            end
            dat_pkg::S_FIN: n_state = dat_pkg::S_IDLE;
            default: n_state = dat_pkg::S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        b_we    = 1'b0;
        c_we    = 1'b0;
        b_waddr = calc_sum[NW-1:0];
        c_waddr = calc_sum[NW-1:0];
        b_wdata = '0;
        c_wdata = {1'b0, r_cur};
        b_raddr = r_cur;
        c_raddr = calc_sum[NW-1:0];
        case (r_state)
            dat_pkg::S_CLEAR: begin
                b_we    = 1'b1;
                c_we    = 1'b1;
                b_waddr = r_clr;
                c_waddr = r_clr;
                c_wdata = '1;
            end
            dat_pkg::S_DEC: begin
                if (r_cnt != '0 && r_tfree) begin
                    b_we    = 1'b1;
                    c_we    = 1'b1;
                    b_waddr = r_t;
                    c_waddr = r_t;
                end
            end
            dat_pkg::S_M0: begin
                b_raddr = calc_sum[NW-1:0];
            end
            dat_pkg::S_M1: begin
                b_we    = 1'b1;
                c_we    = 1'b1;
                b_wdata = b_rdata;
            end
            dat_pkg::S_MGW: begin
                c_we    = r_ok && calc_match;
                c_waddr = r_addr;
                c_wdata = {1'b0, r_t};
            end
            dat_pkg::S_MCLR: begin
                b_we    = 1'b1;
                c_we    = 1'b1;
                b_waddr = r_told;
                c_waddr = r_told;
                c_wdata = '1;
            end
            dat_pkg::S_SETB: begin
                b_we    = 1'b1;
                b_waddr = r_cur;
                b_wdata = {r_b, r_term};
            end
            dat_pkg::S_CLAIM: begin
                b_we = 1'b1;
                c_we = 1'b1;
            end
            dat_pkg::S_FIN: begin
                b_we    = (r_op == dat_pkg::OP_INSERT);
                b_waddr = r_cur;
                b_wdata = {b_rdata[NW:1], 1'b1};
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dat_pkg::S_CLEAR;
            r_clr    <= '0;
            r_cur    <= '0;
            r_dead   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rsp_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                dat_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                dat_pkg::S_IDLE: begin
                    if (accept && !r_dead && sym_bad) r_dead <= 1'b1;
                end
                dat_pkg::S_TCHK: begin
                    if (r_ok && calc_match) r_cur <= r_t;
                    else if (r_op == dat_pkg::OP_LOOKUP) r_dead <= 1'b1;
                    else r_cnt <= '0;
                end
                dat_pkg::S_GW: begin
                    if (r_ok && calc_match) r_cnt <= r_cnt + 1'b1;
                end
                dat_pkg::S_DEC: begin
                    if (r_cnt != '0 && r_tfree) r_cur <= r_t;
                end
                dat_pkg::S_SI: begin
                    if (!calc_inr && (r_k == '0 || r_b == LAST_SLOT)) r_dead <= 1'b1;
                end
                dat_pkg::S_SW: begin
                    if (!calc_unset && r_b == LAST_SLOT) r_dead <= 1'b1;
                end
                dat_pkg::S_CLAIM: r_cur <= calc_sum[NW-1:0];
                dat_pkg::S_END: begin
                    if (r_end && out_free && r_dead) begin
                        r_cur  <= '0;
                        r_dead <= 1'b0;
                    end
                end
                dat_pkg::S_FIN: begin
                    r_cur <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            dat_pkg::S_IDLE: begin
                if (accept) begin
                    r_op  <= i_req.opcode;
                    r_end <= i_req.word_end;
                    r_sym <= DW'(i_req.symbol);
                end
            end
            dat_pkg::S_T: begin
                r_sb   <= b_rdata[NW:1];
                r_term <= b_rdata[0];
                r_t    <= calc_sum[NW-1:0];
                r_ok   <= calc_inr;
            end
            dat_pkg::S_TCHK: begin
                r_tfree <= r_ok && calc_unset;
                r_d     <= DW'(1);
            end
            dat_pkg::S_G: r_ok <= calc_inr;
            dat_pkg::S_GW: begin
                if (r_ok && calc_match) r_clist[IW'(r_cnt)] <= r_d;
                r_d <= r_d + 1'b1;
            end
            dat_pkg::S_DEC: begin
                r_b <= '0;
                r_k <= '0;
            end
            dat_pkg::S_SI: begin
                if (!calc_inr) begin
                    r_b <= r_b + 1'b1;
                    r_k <= '0;
                end
            end
            dat_pkg::S_SW: begin
                r_mk <= '0;
                if (calc_unset) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_b <= r_b + 1'b1;
                    r_k <= '0;
                end
            end
            dat_pkg::S_M0: r_told <= calc_sum[NW-1:0];
            dat_pkg::S_M1: begin
                r_gent <= b_rdata;
                r_t    <= calc_sum[NW-1:0];
                r_d    <= DW'(1);
            end
            dat_pkg::S_MG: begin
                r_addr <= calc_sum[NW-1:0];
                r_ok   <= calc_inr;
            end
            dat_pkg::S_MGW:  r_d  <= r_d + 1'b1;
            dat_pkg::S_MCLR: r_mk <= r_mk + 1'b1;
            dat_pkg::S_END: begin
                if (r_end && out_free && r_dead) begin
                    r_found  <= 1'b0;
                    r_status <= r_op;
                    r_node   <= '0;
                end
            end
            dat_pkg::S_FIN: begin
                r_found  <= (r_op == dat_pkg::OP_INSERT) ? 1'b1 : b_rdata[0];
                r_status <= dat_pkg::STATUS_OK;
                r_node   <= r_cur;
            end
            default: begin
            end
        endcase
    end

    // The clearing pass must hold off all requests.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dat_pkg::S_CLEAR) |-> !i_req.ready)
        else $error("request taken during clearing pass");

    // A full store never reports success.
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == dat_pkg::STATUS_FULL) |->
            (!o_rsp.found && o_rsp.end_node == '0))
        else $error("full status with found or node set");

    // The child count never exceeds the alphabet.
    a_child_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= ALPHABET)
        else $error("child count out of range");

    // A response is only loaded while the register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dat_pkg::S_FIN) |-> (!r_ovalid || o_rsp.ready))
        else $error("response overwritten");

endmodule

`default_nettype wire

// ----- design/dat_ram.sv -----
// Single write port, single read port memory with registered read data.
// Takes its default depth from dat_pkg; holds the base and check arrays of the trie.
`timescale 1ns / 1ps
`default_nettype none

module dat_ram #(
    parameter int DEPTH = dat_pkg::CAPACITY_DEF,
    parameter int WIDTH = 13
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/dat_calc.sv -----
// Shared slot unit: adds a base and a symbol offset, checks the slot bound,
// compares a check entry against a node and flags an unset entry. Depends on dat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dat_calc #(
    parameter int CAPACITY = dat_pkg::CAPACITY_DEF,
    parameter int ALPHABET = dat_pkg::ALPHABET_DEF
) (
    input  wire logic [$clog2(CAPACITY)-1:0]   i_base,
    input  wire logic [$clog2(ALPHABET+1)-1:0] i_offset,
    input  wire logic [$clog2(CAPACITY):0]     i_entry,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_key,
    output logic      [$clog2(CAPACITY):0]     o_sum,
    output logic                               o_in_range,
    output logic                               o_match,
    output logic                               o_unset
);

    localparam int NW = $clog2(CAPACITY);

    always_comb begin
        o_sum      = {1'b0, i_base} + (NW+1)'(i_offset);
        o_in_range = (o_sum < (NW+1)'(CAPACITY));
        o_unset    = i_entry[NW];
        o_match    = (i_entry == {1'b0, i_key});
    end

endmodule

`default_nettype wire
